/* sv/bsoc_pkg.sv */
// ----------------------------------------------------------------------------
// bsoc_pkg: constants and types for the battery state-of-charge lookup
// Axis breakpoints, the state-of-charge table and the per-segment
// division constants, all in the fixed-point units of the datapath.
// ----------------------------------------------------------------------------
package bsoc_pkg;

	localparam int TEMP_POINTS = 4;
	localparam int VOLT_POINTS = 5;

	// Field widths.
	localparam int TEMP_W  = 16;
	localparam int CUR_W   = 18;
	localparam int VOLT_W  = 17;
	localparam int RES_W   = 16;
	localparam int SOC_W   = 15;

	// Internal widths. Open-circuit voltage is held in 1/262144 V.
	localparam int IR_W    = CUR_W + RES_W + 1;   // current times resistance
	localparam int VOC_W   = IR_W + 1;            // plus scaled terminal voltage
	localparam int TWT_W   = 13;                  // temperature weight, max 6400
	localparam int VWT_W   = 24;                  // voltage weight, max 13107200
	localparam int D_W     = 7;                   // table entry, max 100
	localparam int A_W     = 31;                  // one row blended along voltage
	localparam int P_W     = 44;                  // blended row times weight
	localparam int X_W     = 24;                  // numerator after the shift
	localparam int RCP_W   = 28;                  // reciprocal constant
	localparam int PROD_W  = X_W + RCP_W;
	localparam int RCP_SHIFT = 34;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic signed [VOC_W-1:0]  voc_t;
	typedef logic [1:0]               tidx_t;
	typedef logic [1:0]               vidx_t;
	typedef logic [2:0]               vtab_t;
	typedef logic [TWT_W-1:0]         twt_t;
	typedef logic [VWT_W-1:0]         vwt_t;
	typedef logic [D_W-1:0]           dval_t;

	// Temperature axis in 1/256 degree C.
	localparam temp_t TEMP_AXIS [TEMP_POINTS] = '{
		-16'sd2560, 16'sd0, 16'sd6400, 16'sd11520
	};

	// Voltage axis in 1/262144 V (200 V to 400 V in 50 V steps).
	localparam voc_t VOLT_AXIS [VOLT_POINTS] = '{
		36'sd52428800, 36'sd65536000, 36'sd78643200, 36'sd91750400, 36'sd104857600
	};

	// State of charge in percent, rows by temperature, columns by voltage.
	localparam dval_t SOC_TABLE [TEMP_POINTS][VOLT_POINTS] = '{
		'{7'd0, 7'd10, 7'd35, 7'd100, 7'd100},
		'{7'd0, 7'd0,  7'd20, 7'd80,  7'd100},
		'{7'd0, 7'd0,  7'd10, 7'd60,  7'd100},
		'{7'd0, 7'd0,  7'd0,  7'd50,  7'd100}
	};

	// The divisor tspan * vspan / 256 of each temperature segment factors as
	// 2^shift * c with c equal to 125 or 625. The shift is taken first, then
	// c is divided out by ceil(2^34 / c) and a right shift of 34, which is
	// exact for every numerator below 2^25.
	localparam logic [4:0] SEG_SHIFT [TEMP_POINTS-1] = '{5'd20, 5'd19, 5'd21};
	localparam logic [RCP_W-1:0] SEG_RECIP [TEMP_POINTS-1] = '{
		28'd137438954, 28'd27487791, 28'd137438954
	};

endpackage

/* sv/battery_soc_bilinear_lookup_top.sv */
// ----------------------------------------------------------------------------
// battery_soc_bilinear_lookup_top: state of charge by bilinear table lookup
// Throughput: one input transaction per cycle, unless the output stalls,
// through a six-stage pipeline; the two interpolation multiplier stages and
// the reciprocal multiplier set the stage depth. Inputs with no changed
// flag are taken and yield nothing. Reset clears the stage valid bits and
// the resistance register to zero.
// ----------------------------------------------------------------------------
module battery_soc_bilinear_lookup_top
	import bsoc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [RES_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [TEMP_W-1:0] temperature,
	input  logic signed [CUR_W-1:0]  pack_current,
	input  logic [VOLT_W-1:0]        pack_voltage,
	input  logic                     temp_changed,
	input  logic                     current_changed,
	input  logic                     voltage_changed,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SOC_W-1:0]         soc
);

	// Configuration: internal resistance in 1/1024 ohm.
	logic [RES_W-1:0] resistance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resistance_q <= '0;
		end else if (cfg_we) begin
			resistance_q <= cfg_wdata;
		end
	end

	// Pipeline flow control. A stage loads when it is empty or when the
	// stage after it loads in the same cycle, so bubbles are squeezed out;
	// a stalled output holds every occupied stage with no bubble after it.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6    = !vld_s6 || out_ready;
	assign en_s5    = !vld_s5 || en_s6;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// A transaction with none of the changed flags set is consumed here
	// and never enters the pipeline.
	logic take_c;
	assign take_c = in_valid && (temp_changed || current_changed || voltage_changed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= take_c;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: open-circuit voltage Voc = V*1024 + I*R in 1/262144 V,
	// and the temperature clamped to the axis with its segment located.
	// ------------------------------------------------------------------
	logic signed [IR_W-1:0] ir_c;
	voc_t                   voc_c;
	temp_t                  tc_c;
	tidx_t                  ti_c;
	voc_t                   voc_s1;
	tidx_t                  ti_s1;
	twt_t                   tl_s1, th_s1;
	logic signed [TEMP_W:0] tl_c, th_c;

	always_comb begin
		ir_c  = IR_W'(pack_current) * IR_W'($signed({1'b0, resistance_q}));
		voc_c = VOC_W'($signed({1'b0, pack_voltage, 10'b0})) + VOC_W'(ir_c);

		if (temperature < TEMP_AXIS[0]) begin
			tc_c = TEMP_AXIS[0];
		end else if (temperature > TEMP_AXIS[TEMP_POINTS-1]) begin
			tc_c = TEMP_AXIS[TEMP_POINTS-1];
		end else begin
			tc_c = temperature;
		end

		// The lowest segment whose upper point is at or above the value.
		ti_c = tidx_t'(TEMP_POINTS - 2);
		for (int i = TEMP_POINTS - 3; i >= 0; i--) begin
			if (tc_c <= TEMP_AXIS[i+1]) begin
				ti_c = tidx_t'(i);
			end
		end

		tl_c = (TEMP_W+1)'(TEMP_AXIS[ti_c + 2'd1]) - (TEMP_W+1)'(tc_c);
		th_c = (TEMP_W+1)'(tc_c) - (TEMP_W+1)'(TEMP_AXIS[ti_c]);
	end

	always_ff @(posedge clk) begin
		if (en_s1 && take_c) begin
			voc_s1 <= voc_c;
			ti_s1  <= ti_c;
			tl_s1  <= tl_c[TWT_W-1:0];
			th_s1  <= th_c[TWT_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: clamp Voc (negative values included), locate its segment,
	// form the voltage weights and fetch the four corner table entries.
	// ------------------------------------------------------------------
	voc_t  vc_c, vl_c, vh_c;
	vidx_t vi_c;
	vtab_t vlo_c, vhi_c;
	tidx_t ti_s2;
	twt_t  tl_s2, th_s2;
	vwt_t  vl_s2, vh_s2;
	dval_t d00_s2, d01_s2, d10_s2, d11_s2;

	always_comb begin
		if (voc_s1 < VOLT_AXIS[0]) begin
			vc_c = VOLT_AXIS[0];
		end else if (voc_s1 > VOLT_AXIS[VOLT_POINTS-1]) begin
			vc_c = VOLT_AXIS[VOLT_POINTS-1];
		end else begin
			vc_c = voc_s1;
		end

		vi_c = vidx_t'(VOLT_POINTS - 2);
		for (int j = VOLT_POINTS - 3; j >= 0; j--) begin
			if (vc_c <= VOLT_AXIS[j+1]) begin
				vi_c = vidx_t'(j);
			end
		end

		vlo_c = {1'b0, vi_c};
		vhi_c = vlo_c + 3'd1;
		vl_c  = VOLT_AXIS[vhi_c] - vc_c;
		vh_c  = vc_c - VOLT_AXIS[vlo_c];
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			ti_s2  <= ti_s1;
			tl_s2  <= tl_s1;
			th_s2  <= th_s1;
			vl_s2  <= vl_c[VWT_W-1:0];
			vh_s2  <= vh_c[VWT_W-1:0];
			d00_s2 <= SOC_TABLE[ti_s1][vlo_c];
			d01_s2 <= SOC_TABLE[ti_s1][vhi_c];
			d10_s2 <= SOC_TABLE[ti_s1 + 2'd1][vlo_c];
			d11_s2 <= SOC_TABLE[ti_s1 + 2'd1][vhi_c];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: blend each of the two table rows along the voltage axis.
	// ------------------------------------------------------------------
	tidx_t          ti_s3;
	twt_t           tl_s3, th_s3;
	logic [A_W-1:0] alo_s3, ahi_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			ti_s3  <= ti_s2;
			tl_s3  <= tl_s2;
			th_s3  <= th_s2;
			alo_s3 <= A_W'(d00_s2) * A_W'(vl_s2) + A_W'(d01_s2) * A_W'(vh_s2);
			ahi_s3 <= A_W'(d10_s2) * A_W'(vl_s2) + A_W'(d11_s2) * A_W'(vh_s2);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: weight the blended rows along the temperature axis.
	// ------------------------------------------------------------------
	tidx_t          ti_s4;
	logic [P_W-1:0] plo_s4, phi_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			ti_s4  <= ti_s3;
			plo_s4 <= P_W'(alo_s3) * P_W'(tl_s3);
			phi_s4 <= P_W'(ahi_s3) * P_W'(th_s3);
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: sum the numerator and strip the power-of-two part of the
	// segment divisor. Truncation here does not change the final floor.
	// ------------------------------------------------------------------
	logic [P_W-1:0] num_c, numsh_c;
	tidx_t          ti_s5;
	logic [X_W-1:0] x_s5;

	always_comb begin
		num_c   = plo_s4 + phi_s4;
		numsh_c = num_c >> SEG_SHIFT[ti_s4];
	end

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			ti_s5 <= ti_s4;
			x_s5  <= numsh_c[X_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: divide out the odd factor by reciprocal multiplication and
	// hold the result in the output register.
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] prod_c;
	logic [SOC_W-1:0]  soc_s6;

	assign prod_c = PROD_W'(x_s5) * PROD_W'(SEG_RECIP[ti_s5]);

	always_ff @(posedge clk) begin
		if (en_s6 && vld_s5) begin
			soc_s6 <= prod_c[RCP_SHIFT +: SOC_W];
		end
	end

	assign out_valid = vld_s6;
	assign soc       = soc_s6;

endmodule

/* bench/tb_battery_soc_bilinear_lookup_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_soc_bilinear_lookup_top: self-checking bench for the SoC lookup
// Drives readings through the valid/ready input channel, predicts every
// state-of-charge result with exact 64-bit arithmetic, and checks each soc
// transaction in order. Covers axis corners, breakpoints, flag combinations,
// resistance extremes, random readings, back-pressure and full-rate traffic.
// ----------------------------------------------------------------------------
module tb_battery_soc_bilinear_lookup_top;
	import bsoc_pkg::*;

	// Axis breakpoints and table as the bench sees them. Temperature is in
	// 1/256 degree C; open-circuit voltage is in 1/262144 V, which is the
	// terminal voltage times 1024 plus current times resistance.
	localparam int TEMP_N = 4;
	localparam int VOLT_N = 5;
	localparam longint TEMP_BREAKS [TEMP_N] = '{-2560, 0, 6400, 11520};
	localparam longint VOLT_BREAKS [VOLT_N] = '{
		200 * 262144, 250 * 262144, 300 * 262144, 350 * 262144, 400 * 262144
	};
	localparam longint SOC_PERCENT [TEMP_N][VOLT_N] = '{
		'{0, 10, 35, 100, 100},
		'{0, 0,  20, 80,  100},
		'{0, 0,  10, 60,  100},
		'{0, 0,  0,  50,  100}
	};

	// Changed flags, ordered {temperature, current, voltage}.
	localparam logic [2:0] ALL_CHANGED  = 3'b111;

	// drain_pipeline waits out this settle time after the last result is
	// back; flagless readings never enter the pipeline and owe no result.
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int LONG_HOLD     = 120;

	typedef struct {
		temp_t                   temp;
		logic signed [CUR_W-1:0] cur;
		logic [VOLT_W-1:0]       volt;
		logic [2:0]              changed;
	} reading_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [RES_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [TEMP_W-1:0] temperature = '0;
	logic signed [CUR_W-1:0]  pack_current = '0;
	logic [VOLT_W-1:0]        pack_voltage = '0;
	logic                     temp_changed = 1'b0;
	logic                     current_changed = 1'b0;
	logic                     voltage_changed = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [SOC_W-1:0]         soc;

	// Bench copy of the resistance register and the results still owed.
	logic [RES_W-1:0] res_setting = '0;
	logic [SOC_W-1:0] pending_soc [$];

	// Idling controls for the sender (src_gaps) and the receiver (sink_stalls, sink_hold).
	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	int sink_hold = 0;

	int fail_count = 0;
	int readings_sent = 0;
	int readings_flagged = 0;
	int soc_checked = 0;
	int settings_used = 0;
	int cycle_count = 0;

	battery_soc_bilinear_lookup_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.temperature     (temperature),
		.pack_current    (pack_current),
		.pack_voltage    (pack_voltage),
		.temp_changed    (temp_changed),
		.current_changed (current_changed),
		.voltage_changed (voltage_changed),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.soc             (soc)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Exact state of charge for one reading. Both coordinates are clamped to
	// their axis, the lowest segment that holds the value is chosen, and the
	// bilinear blend is scaled by 256 and divided once, so that the floor of
	// the exact quotient comes out. All weights are non-negative here.
	function automatic logic [SOC_W-1:0] soc_from_readings(
		input logic signed [TEMP_W-1:0] t_in,
		input logic signed [CUR_W-1:0]  i_in,
		input logic [VOLT_W-1:0]        v_in,
		input logic [RES_W-1:0]         r_in
	);
		longint t, v, tl, th, vl, vh, num, den;
		int ti, vi, k;
		t = longint'(t_in);
		v = longint'(v_in) * 1024 + longint'(i_in) * longint'(r_in);
		if (t < TEMP_BREAKS[0]) t = TEMP_BREAKS[0];
		if (t > TEMP_BREAKS[TEMP_N-1]) t = TEMP_BREAKS[TEMP_N-1];
		if (v < VOLT_BREAKS[0]) v = VOLT_BREAKS[0];
		if (v > VOLT_BREAKS[VOLT_N-1]) v = VOLT_BREAKS[VOLT_N-1];
		ti = TEMP_N - 2;
		for (k = TEMP_N - 3; k >= 0; k--)
			if (t <= TEMP_BREAKS[k+1]) ti = k;
		vi = VOLT_N - 2;
		for (k = VOLT_N - 3; k >= 0; k--)
			if (v <= VOLT_BREAKS[k+1]) vi = k;
		tl = TEMP_BREAKS[ti+1] - t;
		th = t - TEMP_BREAKS[ti];
		vl = VOLT_BREAKS[vi+1] - v;
		vh = v - VOLT_BREAKS[vi];
		num = SOC_PERCENT[ti][vi] * tl * vl + SOC_PERCENT[ti+1][vi] * th * vl
			+ SOC_PERCENT[ti][vi+1] * tl * vh + SOC_PERCENT[ti+1][vi+1] * th * vh;
		den = (TEMP_BREAKS[ti+1] - TEMP_BREAKS[ti]) * (VOLT_BREAKS[vi+1] - VOLT_BREAKS[vi]);
		return SOC_W'((num * 256) / den);
	endfunction

	function automatic reading_t make_reading(input int t, input int i, input int v,
			input logic [2:0] changed);
		reading_t r;
		r.temp = TEMP_W'(t);
		r.cur = CUR_W'(i);
		r.volt = VOLT_W'(v);
		r.changed = changed;
		return r;
	endfunction

	// Random reading. Most land inside the axes or next to a breakpoint so
	// that every segment is interpolated; the rest span each field's whole
	// range so that every input bit toggles. The current spread shrinks as
	// the resistance grows, which keeps the open-circuit voltage near the axis.
	function automatic reading_t random_reading();
		reading_t r;
		int span;
		case ($urandom_range(0, 9))
			0: r.temp = TEMP_W'($urandom);
			1, 2: r.temp = TEMP_W'(TEMP_BREAKS[$urandom_range(0, TEMP_N-1)]
				+ $urandom_range(0, 2) - 1);
			default: r.temp = TEMP_W'($urandom_range(0, 16000) - 3500);
		endcase
		case ($urandom_range(0, 9))
			0: r.volt = VOLT_W'($urandom);
			1, 2: r.volt = VOLT_W'(51200 + 12800 * $urandom_range(0, VOLT_N-1)
				+ $urandom_range(0, 2) - 1);
			default: r.volt = VOLT_W'($urandom_range(46000, 108000));
		endcase
		span = (res_setting == 0) ? 131071 : 20000000 / res_setting;
		if (span > 131071) span = 131071;
		case ($urandom_range(0, 9))
			0: r.cur = CUR_W'($urandom);
			1: r.cur = '0;
			default: r.cur = CUR_W'($urandom_range(0, 2 * span) - span);
		endcase
		r.changed = 3'($urandom_range(0, 7));
		return r;
	endfunction

	// Offers one reading and returns at the edge where it is accepted. It is
	// always entered at a rising edge, and in_valid gets one assignment there.
	task automatic send_reading(input reading_t r);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		temperature <= r.temp;
		pack_current <= r.cur;
		pack_voltage <= r.volt;
		{temp_changed, current_changed, voltage_changed} <= r.changed;
		do @(posedge clk); while (!in_ready);
	endtask

	// The sender stops and waits until every owed result is back, then waits
	// out the settle time as well.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_soc.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The resistance register is only written with the pipeline empty.
	task automatic set_resistance(input logic [RES_W-1:0] value);
		drain_pipeline();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		res_setting = value;
		settings_used++;
	endtask

	// Corners and breakpoints of both axes with the reset resistance of zero.
	task automatic test_axis_corners();
		send_reading(make_reading(-32768, 0, 0, ALL_CHANGED));
		send_reading(make_reading(32767, 0, 131071, ALL_CHANGED));
		send_reading(make_reading(-32768, 0, 131071, ALL_CHANGED));
		send_reading(make_reading(32767, 0, 0, ALL_CHANGED));
		send_reading(make_reading(-2560, 0, 51200, ALL_CHANGED));
		send_reading(make_reading(11520, 0, 102400, ALL_CHANGED));
		// Inner breakpoints, where the lower segment must be used, then points between and just above them.
		send_reading(make_reading(0, 0, 64000, ALL_CHANGED));
		send_reading(make_reading(6400, 0, 76800, ALL_CHANGED));
		send_reading(make_reading(3200, 0, 70400, ALL_CHANGED));
		send_reading(make_reading(6401, 0, 89601, ALL_CHANGED));
	endtask

	// Every combination of the changed flags; the all-clear one yields nothing.
	task automatic test_flag_combinations();
		int f;
		for (f = 0; f < 8; f++)
			send_reading(make_reading(2000, 1000, 80000, f[2:0]));
	endtask

	// The largest resistance with the extreme currents drives the open-circuit
	// voltage far below zero and far above the axis; the smallest adds a
	// fraction of a volt.
	task automatic test_resistance_extremes();
		set_resistance(16'hFFFF);
		send_reading(make_reading(1000, -131072, 131071, ALL_CHANGED));
		send_reading(make_reading(1000, 131071, 0, ALL_CHANGED));
		send_reading(make_reading(1000, 256, 64000, ALL_CHANGED));
		set_resistance(16'h0001);
		send_reading(make_reading(-1, 131071, 51200, ALL_CHANGED));
		send_reading(make_reading(8000, -131072, 102400, ALL_CHANGED));
		send_reading(make_reading(4000, -1, 76800, ALL_CHANGED));
	endtask

	// Random readings under several resistance settings. Each change of
	// setting also makes the sender wait until all results have come back.
	task automatic test_random_settings();
		logic [RES_W-1:0] settings [6];
		int s, n;
		settings = '{16'd0, 16'd1024, 16'hFFFF, RES_W'($urandom), RES_W'($urandom), 16'd1};
		for (s = 0; s < 6; s++) begin
			set_resistance(settings[s]);
			for (n = 0; n < 80; n++)
				send_reading(random_reading());
		end
	endtask

	// The receiver holds off for a long stretch while the sender offers
	// readings back to back, so the pipeline fills and in_ready drops.
	task automatic test_output_backpressure();
		reading_t r;
		int n;
		src_gaps = 1'b0;
		sink_hold = LONG_HOLD;
		for (n = 0; n < 40; n++) begin
			r = random_reading();
			r.changed[0] = 1'b1;
			send_reading(r);
		end
		src_gaps = 1'b1;
	endtask

	// Last part of the run: no idling on either side.
	task automatic test_full_rate();
		int n;
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		for (n = 0; n < 100; n++)
			send_reading(random_reading());
	endtask

	// Receiver: random stall bursts, or a single long hold-off on request.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Every accepted input transaction with a changed flag owes one result.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			readings_sent++;
			if (temp_changed || current_changed || voltage_changed) begin
				readings_flagged++;
				pending_soc.push_back(soc_from_readings(temperature, pack_current,
					pack_voltage, res_setting));
			end
		end
	end

	// Each output transaction is matched against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_soc.size() == 0) begin
				$error("soc: no result expected, actual %0d", soc);
				fail_count++;
			end else begin
				if (soc !== pending_soc[0]) begin
					$error("soc mismatch: expected %0d, actual %0d", pending_soc[0], soc);
					fail_count++;
				end
				void'(pending_soc.pop_front());
				soc_checked++;
			end
		end
	end

	// A result that never arrives shows up here as a timeout.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_battery_soc_bilinear_lookup_top failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_axis_corners();
		test_flag_combinations();
		test_resistance_extremes();
		test_random_settings();
		test_output_backpressure();
		test_full_rate();
		drain_pipeline();
		$display("Sent %0d readings (%0d with a changed flag) under %0d resistance settings.",
			readings_sent, readings_flagged, settings_used);
		$display("Checked %0d state-of-charge results in %0d cycles.", soc_checked, cycle_count);
		if (fail_count == 0) begin
			$display("tb_battery_soc_bilinear_lookup_top passed");
		end else begin
			$display("tb_battery_soc_bilinear_lookup_top failed");
		end
		$finish;
	end

endmodule
